@@ rtl/core/rss_pkg.sv @@
// Shared widths, command and status codes for the random sample set.
`default_nettype none

package rss_pkg;

  localparam int KEY_WIDTH    = 32;
  localparam int RAND_WIDTH   = 16;
  localparam int CMD_WIDTH    = 2;
  localparam int STATUS_WIDTH = 3;
  localparam int SIZE_WIDTH   = 7;
  localparam int SLOT_WIDTH   = 6;

  typedef logic [CMD_WIDTH-1:0]    cmd_t;
  typedef logic [STATUS_WIDTH-1:0] status_t;
  typedef logic [KEY_WIDTH-1:0]    key_t;
  typedef logic [RAND_WIDTH-1:0]   rand_t;
  typedef logic [SIZE_WIDTH-1:0]   size_t;
  typedef logic [SLOT_WIDTH-1:0]   slot_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_PICK   = 2'd2;

  localparam status_t ST_DONE    = 3'd0;
  localparam status_t ST_PRESENT = 3'd1;
  localparam status_t ST_ABSENT  = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_EMPTY   = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/rss_req_if.sv @@
// Command channel of the random sample set: valid, ready and the command beat.
`default_nettype none

interface rss_req_if;
  logic               valid;
  logic               ready;
  rss_pkg::cmd_t      cmd;
  rss_pkg::key_t      key;
  rss_pkg::rand_t     rand_value;

  modport source (output valid, output cmd, output key, output rand_value, input ready);
  modport sink   (input valid, input cmd, input key, input rand_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rss_rsp_if.sv @@
// Response channel of the random sample set: valid, ready and the result beat.
`default_nettype none

interface rss_rsp_if;
  logic               valid;
  logic               ready;
  rss_pkg::key_t      element;
  rss_pkg::status_t   status;
  rss_pkg::size_t     set_size;
  rss_pkg::slot_t     slot;

  modport source (output valid, output element, output status, output set_size,
                  output slot, input ready);
  modport sink   (input valid, input element, input status, input set_size,
                  input slot, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rss_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/random_sample_set.sv @@
// Random sample set: distinct keys held densely in a RAM, with insert, remove and random pick.
//
// Commands arrive on req (cmd, key, rand_value) and each produces exactly one
// beat on rsp (element, status, set_size, slot). req.ready is high only while
// the sequencer is idle; one command is worked on at a time.
// Insert and remove scan the occupied slots through the single RAM read port,
// one slot per cycle; a hit ends the scan early, and a remove that hits then
// moves the last key into the vacated slot (states S_MOVE_RD and S_MOVE_WR).
// A pick divides rand_value by the set size with a restoring divider, one
// quotient bit per cycle, then reads the slot at the remainder.
// Other commands and a pick from an empty set go straight from idle to S_FIN.
// The result sits in an output register, so the next command is accepted while
// a beat waits on a stalled receiver; a further result then waits until the
// receiver takes the first.
// Reset empties the set and drops any pending beat; slot contents are left as
// they are and are never read before being written.
`default_nettype none

module random_sample_set #(
  parameter int CAPACITY = 64
) (
  input wire logic clk,
  input wire logic rst,
  rss_req_if.sink   req,
  rss_rsp_if.source rsp
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int DCW = $clog2(rss_pkg::RAND_WIDTH);
  localparam int KW  = rss_pkg::KEY_WIDTH;
  localparam int RW  = rss_pkg::RAND_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SCAN      = 8'b0000_0010,
    S_MOVE_RD   = 8'b0000_0100,
    S_MOVE_WR   = 8'b0000_1000,
    S_DIV       = 8'b0001_0000,
    S_PICK_RD   = 8'b0010_0000,
    S_PICK_WAIT = 8'b0100_0000,
    S_FIN       = 8'b1000_0000
  } state_t;

  state_t state;

  rss_pkg::cmd_t    cmd_q;
  rss_pkg::key_t    key_q;
  rss_pkg::rand_t   rand_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    scan_idx;
  logic             chk_valid;
  logic [IW-1:0]    chk_idx;
  logic [IW-1:0]    pos;
  logic [CW-1:0]    rem;
  logic [DCW-1:0]   div_cnt;

  rss_pkg::key_t    res_element;
  rss_pkg::status_t res_status;
  logic [IW-1:0]    res_slot;

  logic             out_valid;
  rss_pkg::key_t    out_element;
  rss_pkg::status_t out_status;
  rss_pkg::size_t   out_size;
  rss_pkg::slot_t   out_slot;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [KW-1:0]    ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [KW-1:0]    ram_rdata;

  logic             issue;
  logic             match;
  logic             not_found;
  logic             full;
  logic [CW-1:0]    last_idx;
  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;
  logic             trial_ge;
  logic             out_free;

  rss_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign issue     = (state == S_SCAN) && (scan_idx < count);
  assign match     = chk_valid && (ram_rdata == key_q);
  assign not_found = !match && !chk_valid && !issue;
  assign full      = (count == CW'(CAPACITY));
  assign last_idx  = count - CW'(1);
  assign trial     = {rem, rand_q[RW-1]};
  assign trial_sub = trial - {1'b0, count};
  assign trial_ge  = (trial >= {1'b0, count});
  assign out_free  = !out_valid || rsp.ready;

  // RAM port selection: scan reads, slot move and pick share the one read port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      S_SCAN: begin
        ram_raddr = scan_idx[IW-1:0];
        if (not_found && (cmd_q == rss_pkg::CMD_INSERT) && !full) begin
          ram_we    = 1'b1;
          ram_waddr = count[IW-1:0];
          ram_wdata = key_q;
        end
      end
      S_MOVE_RD: ram_raddr = last_idx[IW-1:0];
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos;
        ram_wdata = ram_rdata;
      end
      S_PICK_RD: ram_raddr = rem[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q     <= req.cmd;
            key_q     <= req.key;
            rand_q    <= req.rand_value;
            scan_idx  <= '0;
            chk_valid <= 1'b0;
            rem       <= '0;
            div_cnt   <= '0;
            unique case (req.cmd)
              rss_pkg::CMD_INSERT, rss_pkg::CMD_REMOVE: state <= S_SCAN;
              rss_pkg::CMD_PICK: begin
                if (count == '0) begin
                  res_element <= '0;
                  res_status  <= rss_pkg::ST_EMPTY;
                  res_slot    <= '0;
                  state       <= S_FIN;
                end else begin
                  state <= S_DIV;
                end
              end
              default: begin
                res_element <= req.key;
                res_status  <= rss_pkg::ST_DONE;
                res_slot    <= '0;
                state       <= S_FIN;
              end
            endcase
          end
        end

        S_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= scan_idx[IW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          res_element <= key_q;
          if (match) begin
            chk_valid <= 1'b0;
            if (cmd_q == rss_pkg::CMD_INSERT) begin
              res_status <= rss_pkg::ST_PRESENT;
              res_slot   <= chk_idx;
              state      <= S_FIN;
            end else begin
              pos   <= chk_idx;
              state <= S_MOVE_RD;
            end
          end else if (not_found) begin
            res_slot <= '0;
            state    <= S_FIN;
            if (cmd_q == rss_pkg::CMD_INSERT) begin
              if (full) begin
                res_status <= rss_pkg::ST_FULL;
              end else begin
                res_status <= rss_pkg::ST_DONE;
                res_slot   <= count[IW-1:0];
                count      <= count + CW'(1);
              end
            end else begin
              res_status <= rss_pkg::ST_ABSENT;
            end
          end
        end

        S_MOVE_RD: state <= S_MOVE_WR;

        S_MOVE_WR: begin
          // The last key now fills the vacated slot.
          count      <= last_idx;
          res_status <= rss_pkg::ST_DONE;
          res_slot   <= pos;
          state      <= S_FIN;
        end

        S_DIV: begin
          rem     <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
          rand_q  <= {rand_q[RW-2:0], 1'b0};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(RW - 1)) begin
            state <= S_PICK_RD;
          end
        end

        S_PICK_RD: state <= S_PICK_WAIT;

        S_PICK_WAIT: begin
          res_element <= ram_rdata;
          res_status  <= rss_pkg::ST_DONE;
          res_slot    <= rem[IW-1:0];
          state       <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_element <= res_element;
            out_status  <= res_status;
            out_size    <= rss_pkg::SIZE_WIDTH'(count);
            out_slot    <= rss_pkg::SLOT_WIDTH'(res_slot);
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.element  = out_element;
  assign rsp.status   = out_status;
  assign rsp.set_size = out_size;
  assign rsp.slot     = out_slot;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("set size exceeds capacity");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ($past(state) == S_SCAN) || ($past(state) == S_MOVE_WR))
    else $error("set size changed outside insert or remove");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) || (state == S_PICK_RD)) |-> (rem < count))
    else $error("pick remainder not below set size");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == rss_pkg::ST_EMPTY)) |->
      ((out_element == '0) && (out_size == '0)))
    else $error("empty pick beat carries data");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the random sample set: command beats in, result beats checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int            SET_CAPACITY = 64;
  localparam int            POOL_DEPTH   = 96;
  localparam rss_pkg::cmd_t CMD_UNUSED   = 2'd3;

  typedef struct packed {
    rss_pkg::key_t    element;
    rss_pkg::status_t status;
    rss_pkg::size_t   set_size;
    rss_pkg::slot_t   slot;
  } result_beat_t;

  logic clk;
  logic rst;

  rss_req_if req_ch ();
  rss_rsp_if rsp_ch ();

  random_sample_set #(
    .CAPACITY(SET_CAPACITY)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Mirror of the set contents, updated as each command beat is accepted.
  rss_pkg::key_t held_keys [SET_CAPACITY];
  int            held_count;
  rss_pkg::key_t key_pool [POOL_DEPTH];
  result_beat_t  pending_results [$];
  int            mismatch_count;
  int            src_idle_pct;
  int            snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic result_beat_t predict_result(rss_pkg::cmd_t c, rss_pkg::key_t k,
                                                  rss_pkg::rand_t r);
    result_beat_t res;
    int           hit;
    int           i;
    int           pick_idx;
    res.element = k;
    res.status  = rss_pkg::ST_DONE;
    res.slot    = '0;
    hit = -1;
    for (i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == k) hit = i;
    end
    case (c)
      rss_pkg::CMD_INSERT: begin
        if (hit >= 0) begin
          res.status = rss_pkg::ST_PRESENT;
          res.slot   = rss_pkg::slot_t'(hit);
        end else if (held_count >= SET_CAPACITY) begin
          res.status = rss_pkg::ST_FULL;
        end else begin
          held_keys[held_count] = k;
          res.slot   = rss_pkg::slot_t'(held_count);
          held_count++;
        end
      end
      rss_pkg::CMD_REMOVE: begin
        if (hit < 0) begin
          res.status = rss_pkg::ST_ABSENT;
        end else begin
          // The last key fills the hole; removing the last key overwrites itself.
          held_keys[hit] = held_keys[held_count-1];
          held_count--;
          res.slot = rss_pkg::slot_t'(hit);
        end
      end
      rss_pkg::CMD_PICK: begin
        if (held_count == 0) begin
          res.status  = rss_pkg::ST_EMPTY;
          res.element = '0;
        end else begin
          pick_idx    = int'(r) % held_count;
          res.element = held_keys[pick_idx];
          res.slot    = rss_pkg::slot_t'(pick_idx);
        end
      end
      default: begin
      end
    endcase
    res.set_size = rss_pkg::size_t'(held_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // This task only lowers valid for idle cycles, so back-to-back beats keep it high.
  task automatic send_command(input rss_pkg::cmd_t c, input rss_pkg::key_t k,
                              input rss_pkg::rand_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.key        <= k;
    req_ch.rand_value <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results = {pending_results, predict_result(c, k, r)};
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    result_beat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing outstanding", rsp_ch.element, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.element !== want.element)
          report_mismatch("element", rsp_ch.element, want.element);
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.set_size !== want.set_size)
          report_mismatch("set_size", 32'(rsp_ch.set_size), 32'(want.set_size));
        if (rsp_ch.slot !== want.slot)
          report_mismatch("slot", 32'(rsp_ch.slot), 32'(want.slot));
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic rss_pkg::key_t live_key();
    return held_keys[$urandom_range(held_count-1)];
  endfunction

  task automatic test_empty_set();
    send_command(rss_pkg::CMD_PICK, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(rss_pkg::CMD_REMOVE, 32'h0000_0000, 16'h0000);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_UNUSED, 32'h0000_0000, 16'h0000);
  endtask

  task automatic test_insert_remove_pick();
    send_command(rss_pkg::CMD_INSERT, 32'h0000_0000, 16'hFFFF);
    send_command(rss_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
    send_command(rss_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000);
    send_command(rss_pkg::CMD_INSERT, 32'h8000_0001, 16'h1234);
    send_command(rss_pkg::CMD_PICK, 32'h0000_0000, 16'h0000);
    send_command(rss_pkg::CMD_PICK, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(rss_pkg::CMD_PICK, 32'h5555_5555, 16'h8001);
    send_command(rss_pkg::CMD_REMOVE, 32'h1234_5678, 16'h0000);
    // The key in the last slot is removed first, then one from the front.
    send_command(rss_pkg::CMD_REMOVE, 32'h8000_0001, 16'h0000);
    send_command(rss_pkg::CMD_REMOVE, 32'h0000_0000, 16'hFFFF);
    send_command(rss_pkg::CMD_PICK, 32'h0000_0000, 16'hAAAA);
    send_command(rss_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    send_command(rss_pkg::CMD_PICK, 32'h0000_0000, 16'h5555);
  endtask

  task automatic test_fill_and_drain();
    int guard;
    guard = 0;
    while (held_count < SET_CAPACITY && guard < 4 * SET_CAPACITY) begin
      send_command(rss_pkg::CMD_INSERT, rss_pkg::key_t'($urandom),
                   rss_pkg::rand_t'($urandom_range(65535)));
      guard++;
    end
    send_command(rss_pkg::CMD_INSERT, rss_pkg::key_t'($urandom),
                 rss_pkg::rand_t'($urandom_range(65535)));
    send_command(rss_pkg::CMD_INSERT, live_key(), rss_pkg::rand_t'($urandom_range(65535)));
    repeat (3) send_command(rss_pkg::CMD_PICK, rss_pkg::key_t'($urandom),
                            rss_pkg::rand_t'($urandom_range(65535)));
    send_command(rss_pkg::CMD_PICK, rss_pkg::key_t'($urandom), 16'hFFFF);
    while (held_count > 0) begin
      if ($urandom_range(99) < 5)
        send_command(rss_pkg::CMD_REMOVE, rss_pkg::key_t'($urandom),
                     rss_pkg::rand_t'($urandom_range(65535)));
      else
        send_command(rss_pkg::CMD_REMOVE, live_key(),
                     rss_pkg::rand_t'($urandom_range(65535)));
      if ($urandom_range(99) < 10)
        send_command(rss_pkg::CMD_PICK, rss_pkg::key_t'($urandom),
                     rss_pkg::rand_t'($urandom_range(65535)));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int            n;
    int            insert_pct;
    int            roll;
    rss_pkg::cmd_t c;
    rss_pkg::key_t k;
    insert_pct = 50;
    for (n = 0; n < n_items; n++) begin
      // Drift between growing and shrinking so the set visits full and empty.
      if (n % 40 == 0) insert_pct = 20 + 30 * $urandom_range(2);
      if (n == n_items / 2) hold_until_drained();
      roll = $urandom_range(99);
      if (roll < 2) begin
        c = CMD_UNUSED;
      end else if (roll < 25) begin
        c = rss_pkg::CMD_PICK;
      end else if ($urandom_range(99) < insert_pct) begin
        c = rss_pkg::CMD_INSERT;
      end else begin
        c = rss_pkg::CMD_REMOVE;
      end
      if (c == rss_pkg::CMD_REMOVE && held_count > 0 && $urandom_range(99) < 60) begin
        k = live_key();
      end else if ($urandom_range(99) < 85) begin
        k = key_pool[$urandom_range(POOL_DEPTH-1)];
      end else begin
        k = rss_pkg::key_t'($urandom);
      end
      send_command(c, k, rss_pkg::rand_t'($urandom_range(65535)));
    end
  endtask

  initial begin : main_sequence
    int i;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = rss_pkg::CMD_INSERT;
    req_ch.key        = '0;
    req_ch.rand_value = '0;
    rsp_ch.ready      = 1'b0;
    held_count        = 0;
    mismatch_count    = 0;
    src_idle_pct      = 6;
    snk_idle_pct      = 51;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < POOL_DEPTH; i++) key_pool[i] = rss_pkg::key_t'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_set();
    test_insert_remove_pick();
    test_fill_and_drain();
    test_random_traffic(250);

    src_idle_pct = 51;
    snk_idle_pct = 6;
    test_fill_and_drain();
    test_random_traffic(250);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_fill_and_drain();
    test_random_traffic(250);

    hold_until_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
